FILE: design/rpn_pkg.sv
// Shared types, constants and codes for the RPN stack evaluator.
// Depends on nothing; every other design file but rpn_ram imports it.
package rpn_pkg;

	localparam int STACK_DEPTH   = 16;
	localparam int FRACTION_BITS = 16;
	localparam int DATA_W        = 32;
	localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W         = $clog2(STACK_DEPTH);

	// Divider sizing: two quotient bits per cycle over the scaled dividend
	localparam int DIV_W      = DATA_W + FRACTION_BITS;
	localparam int DIV_STEPS  = (DIV_W + 1) / 2;
	localparam int DIV_PAD_W  = 2 * DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam logic KIND_OPERAND  = 1'b0;
	localparam logic KIND_OPERATOR = 1'b1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2,
		ERR_DIVZ  = 2'd3
	} err_t;

	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_UNDER = 3'd1;
	localparam logic [2:0] STAT_OVER  = 3'd2;
	localparam logic [2:0] STAT_DIVZ  = 3'd3;
	localparam logic [2:0] STAT_EMPTY = 3'd4;

	typedef struct packed {
		logic                     kind;
		logic signed [DATA_W-1:0] operand_value;
		logic [1:0]               operator_code;
		logic                     last_token;
	} token_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] result_value;
		logic [2:0]               status;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_tok;
		logic push_operand;
		logic set_under;
		logic latch_left;
		logic mul_start;
		logic div_start;
		logic push_result;
		logic emit;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic kind;
		logic last;
		logic is_div;
		logic under;
		logic lt2;
		logic right_zero;
		logic div_done;
		logic out_blocked;
	} dp_sts_t;

endpackage

FILE: design/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl and rpn_dp.
//
//   channel   valid          stall          payload
//   token     token_valid    token_stall    token  (rpn_pkg::token_t)
//   result    result_valid   result_stall   result (rpn_pkg::result_t)
//
// One token at a time on Q16.16 values: an operand passes through decode and done;
// add, subtract and multiply through decode, read, execute, write and done; a divide
// also waits in the divide state for the two-bit-per-cycle divider, which a divide
// by zero skips. A last token is emitted from done unless the result
// register is still held by result_stall, in which case the controller waits.
// Reset clears the stack count, error and result valid; no clearing pass.
module rpn_stack_evaluator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_stall,
	input  rpn_pkg::token_t  token,
	output logic             result_valid,
	input  logic             result_stall,
	output rpn_pkg::result_t result
);
	import rpn_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rpn_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	rpn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.token        (token),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: design/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module rpn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: design/rpn_div.sv
// Iterative signed fixed-point divider, two quotient bits per cycle, saturating.
// Depends on rpn_pkg.
module rpn_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [rpn_pkg::DATA_W-1:0] dividend,
	input  logic signed [rpn_pkg::DATA_W-1:0] divisor,
	output logic                             done,
	output logic signed [rpn_pkg::DATA_W-1:0] quotient
);
	import rpn_pkg::*;

	logic [DIV_PAD_W-1:0] num_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    den_q;
	logic                 neg_q;
	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DIV_PAD_W-1:0] num_nx;
	logic [DATA_W-1:0]    rem_nx;
	logic [DATA_W-1:0]    a_mag;
	logic [DATA_W-1:0]    b_mag;

	// Magnitudes of the operands
	assign a_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign b_mag = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;

	// Two restoring steps
	always_comb begin
		logic [DATA_W:0] trial;
		num_nx = num_q;
		rem_nx = rem_q;
		trial  = '0;
		for (int i = 0; i < 2; i++) begin
			trial  = {rem_nx, num_nx[DIV_PAD_W-1]};
			num_nx = {num_nx[DIV_PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				trial     = trial - {1'b0, den_q};
				num_nx[0] = 1'b1;
			end
			rem_nx = trial[DATA_W-1:0];
		end
	end

	// Load operands, then advance until all steps are done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				done   <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					done <= 1'b0;
				end
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= DIV_PAD_W'(a_mag) << FRACTION_BITS;
			rem_q <= '0;
			den_q <= b_mag;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
		end
	end

	// Apply sign and saturate
	always_comb begin
		if (neg_q) begin
			if ((|(num_q >> 32)) || (num_q[31] && (|num_q[30:0]))) begin
				quotient = Q_MIN;
			end else begin
				quotient = ~num_q[DATA_W-1:0] + 1'b1;
			end
		end else begin
			if (|(num_q >> 31)) begin
				quotient = Q_MAX;
			end else begin
				quotient = num_q[DATA_W-1:0];
			end
		end
	end

endmodule

FILE: design/rpn_dp.sv
// Datapath: token register, operand stack RAM, count and error, ALU, divider,
// result register. Depends on rpn_pkg, rpn_ram and rpn_div.
module rpn_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rpn_pkg::token_t     token,
	input  rpn_pkg::dp_cmd_t    cmd,
	output rpn_pkg::dp_sts_t    sts,
	output logic                result_valid,
	input  logic                result_stall,
	output rpn_pkg::result_t    result
);
	import rpn_pkg::*;

	token_t                   tok_q;
	logic signed [DATA_W-1:0] left_q;
	logic signed [DATA_W-1:0] right_q;
	logic signed [DATA_W-1:0] top_q;
	logic [CNT_W-1:0]         count_q;
	err_t                     err_q;
	logic signed [2*DATA_W-1:0] prod_s1;

	logic                     wr_en;
	logic [IDX_W-1:0]         wr_addr;
	logic signed [DATA_W-1:0] wr_data;
	logic [CNT_W-1:0]         second_idx;
	logic [DATA_W-1:0]        rd_data;

	logic signed [DATA_W-1:0] div_q;
	logic                     div_done;
	logic signed [DATA_W-1:0] alu_res;
	logic signed [DATA_W:0]   sum_add;
	logic signed [DATA_W:0]   sum_sub;
	logic signed [2*DATA_W-1:0] prod_sh;
	logic                     full;
	logic                     divz;

	assign full       = (count_q >= CNT_W'(STACK_DEPTH));
	assign second_idx = count_q - CNT_W'(2);
	assign divz       = (op_t'(tok_q.operator_code) == OP_DIV) && (right_q == '0);

	// Stack writes: operand push or operator result, always at the count
	assign wr_en   = (cmd.push_operand && !full) || cmd.push_result;
	assign wr_addr = count_q[IDX_W-1:0];
	assign wr_data = cmd.push_result ? alu_res : tok_q.operand_value;

	rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (second_idx[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (left_q),
		.divisor  (right_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Operator result with saturation
	always_comb begin
		sum_add = {left_q[DATA_W-1], left_q} + {right_q[DATA_W-1], right_q};
		sum_sub = {left_q[DATA_W-1], left_q} - {right_q[DATA_W-1], right_q};
		prod_sh = prod_s1 >>> FRACTION_BITS;
		unique case (op_t'(tok_q.operator_code))
			OP_ADD: begin
				if (sum_add[DATA_W] != sum_add[DATA_W-1]) begin
					alu_res = sum_add[DATA_W] ? Q_MIN : Q_MAX;
				end else begin
					alu_res = sum_add[DATA_W-1:0];
				end
			end
			OP_SUB: begin
				if (sum_sub[DATA_W] != sum_sub[DATA_W-1]) begin
					alu_res = sum_sub[DATA_W] ? Q_MIN : Q_MAX;
				end else begin
					alu_res = sum_sub[DATA_W-1:0];
				end
			end
			OP_MUL: begin
				if ((&prod_sh[2*DATA_W-1:DATA_W-1]) || !(|prod_sh[2*DATA_W-1:DATA_W-1])) begin
					alu_res = prod_sh[DATA_W-1:0];
				end else begin
					alu_res = prod_sh[2*DATA_W-1] ? Q_MIN : Q_MAX;
				end
			end
			OP_DIV: begin
				if (right_q == '0) begin
					if (left_q > 0) begin
						alu_res = Q_MAX;
					end else if (left_q < 0) begin
						alu_res = Q_MIN;
					end else begin
						alu_res = '0;
					end
				end else begin
					alu_res = div_q;
				end
			end
		endcase
	end

	// Status to the controller
	always_comb begin
		sts.kind        = tok_q.kind;
		sts.last        = tok_q.last_token;
		sts.is_div      = (op_t'(tok_q.operator_code) == OP_DIV);
		sts.under       = (err_q == ERR_UNDER);
		sts.lt2         = (count_q < CNT_W'(2));
		sts.right_zero  = (right_q == '0);
		sts.div_done    = div_done;
		sts.out_blocked = result_valid && result_stall;
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			tok_q <= token;
		end
		if (cmd.latch_left) begin
			left_q  <= rd_data;
			right_q <= top_q;
		end
		if (cmd.mul_start) begin
			prod_s1 <= left_q * right_q;
		end
		if (cmd.push_operand && !full) begin
			top_q <= tok_q.operand_value;
		end
		if (cmd.push_result) begin
			top_q <= alu_res;
		end
		if (cmd.emit) begin
			if (err_q != ERR_NONE || count_q == '0) begin
				result.result_value <= '0;
			end else begin
				result.result_value <= top_q;
			end
			unique case (err_q)
				ERR_NONE:  result.status <= (count_q == '0) ? STAT_EMPTY : STAT_OK;
				ERR_UNDER: result.status <= STAT_UNDER;
				ERR_OVER:  result.status <= STAT_OVER;
				ERR_DIVZ:  result.status <= STAT_DIVZ;
			endcase
		end
	end

	// Stack count, error and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			err_q        <= ERR_NONE;
			result_valid <= 1'b0;
		end else begin
			if (cmd.emit) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
			if (cmd.push_operand) begin
				if (full) begin
					if (err_q == ERR_NONE) begin
						err_q <= ERR_OVER;
					end
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.set_under) begin
				err_q <= ERR_UNDER;
			end
			if (cmd.latch_left) begin
				count_q <= second_idx;
			end
			if (cmd.push_result) begin
				count_q <= count_q + 1'b1;
				if (divz && err_q == ERR_NONE) begin
					err_q <= ERR_DIVZ;
				end
			end
			if (cmd.emit) begin
				count_q <= '0;
				err_q   <= ERR_NONE;
			end
		end
	end

endmodule

FILE: design/rpn_ctrl.sv
// Controller state machine: sequences one token through decode, stack read,
// execute, write back and result delivery. Depends on rpn_pkg.
module rpn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             token_valid,
	output logic             token_stall,
	input  rpn_pkg::dp_sts_t sts,
	output rpn_pkg::dp_cmd_t cmd
);
	import rpn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_EXEC,
		ST_DIV,
		ST_WRITE,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_nx;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (token_valid && !token_stall) begin
					cmd.load_tok = 1'b1;
					state_nx     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (sts.under) begin
					state_nx = ST_DONE;
				end else if (sts.kind == KIND_OPERAND) begin
					cmd.push_operand = 1'b1;
					state_nx         = ST_DONE;
				end else if (sts.lt2) begin
					cmd.set_under = 1'b1;
					state_nx      = ST_DONE;
				end else begin
					state_nx = ST_READ;
				end
			end
			ST_READ: begin
				cmd.latch_left = 1'b1;
				state_nx       = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.is_div && !sts.right_zero) begin
					cmd.div_start = 1'b1;
					state_nx      = ST_DIV;
				end else begin
					cmd.mul_start = 1'b1;
					state_nx      = ST_WRITE;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_nx = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.push_result = 1'b1;
				state_nx        = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.last) begin
					state_nx = ST_IDLE;
				end else if (!sts.out_blocked) begin
					cmd.emit = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Hold state and registered stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			token_stall <= 1'b0;
		end else begin
			state_q     <= state_nx;
			token_stall <= (state_nx != ST_IDLE);
		end
	end

endmodule

FILE: verif/rpn_stack_evaluator_test.sv
// Self-checking testbench for rpn_stack_evaluator: drives postfix token streams
// with random gaps and stalls, predicts each expression result in a scoreboard.
// Depends on rpn_pkg and the rpn_stack_evaluator design files.
`timescale 1ns / 1ps

module rpn_stack_evaluator_test;
	import rpn_pkg::*;

	localparam int IDLE_LIMIT   = 5000;
	localparam int TOKEN_TARGET = 1000;
	localparam int DRAIN_CYCLES = 80;

	// Expression evaluator: tracks the operand stack and queues expected results
	class expr_checker;
		logic signed [DATA_W-1:0] stack_q [STACK_DEPTH];
		int depth;
		err_t err;
		result_t results_due [$];
		int fails;

		function new();
			depth = 0;
			err = ERR_NONE;
			fails = 0;
		endfunction

		function void note_failure(string msg);
			fails++;
			if (fails <= 10) begin
				$display("mismatch: %s", msg);
			end
		endfunction

		function void note_err(err_t e);
			if (err == ERR_NONE) begin
				err = e;
			end
		endfunction

		function logic signed [DATA_W-1:0] clamp_q(longint v);
			if (v > longint'(Q_MAX)) begin
				return Q_MAX;
			end
			if (v < longint'(Q_MIN)) begin
				return Q_MIN;
			end
			return v[DATA_W-1:0];
		endfunction

		function void push_q(logic signed [DATA_W-1:0] v);
			if (depth >= STACK_DEPTH) begin
				note_err(ERR_OVER);
			end else begin
				stack_q[depth] = v;
				depth++;
			end
		endfunction

		function logic signed [DATA_W-1:0] combine(longint left, longint right, op_t op);
			case (op)
				OP_ADD: return clamp_q(left + right);
				OP_SUB: return clamp_q(left - right);
				// arithmetic shift rounds toward minus infinity
				OP_MUL: return clamp_q((left * right) >>> FRACTION_BITS);
				default: begin
					if (right == 0) begin
						note_err(ERR_DIVZ);
						if (left > 0) begin
							return Q_MAX;
						end
						if (left < 0) begin
							return Q_MIN;
						end
						return '0;
					end
					return clamp_q((left <<< FRACTION_BITS) / right);
				end
			endcase
		endfunction

		// Apply one accepted request; a last token closes the expression
		function void take_token(token_t t);
			longint left, right;
			result_t want;
			if (err != ERR_UNDER) begin
				if (t.kind == KIND_OPERAND) begin
					push_q(t.operand_value);
				end else if (depth < 2) begin
					err = ERR_UNDER;
				end else begin
					right = stack_q[depth-1];
					left = stack_q[depth-2];
					depth -= 2;
					push_q(combine(left, right, op_t'(t.operator_code)));
				end
			end
			if (t.last_token) begin
				want.result_value = '0;
				case (err)
					ERR_UNDER: want.status = STAT_UNDER;
					ERR_OVER:  want.status = STAT_OVER;
					ERR_DIVZ:  want.status = STAT_DIVZ;
					default: begin
						if (depth == 0) begin
							want.status = STAT_EMPTY;
						end else begin
							want.status = STAT_OK;
							want.result_value = stack_q[depth-1];
						end
					end
				endcase
				results_due.push_back(want);
				depth = 0;
				err = ERR_NONE;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (results_due.size() == 0) begin
				note_failure($sformatf("unexpected result value %h status %0d",
					got.result_value, got.status));
				return;
			end
			want = results_due.pop_front();
			if (got.result_value !== want.result_value) begin
				note_failure($sformatf("result_value expected %h got %h",
					want.result_value, got.result_value));
			end
			if (got.status !== want.status) begin
				note_failure($sformatf("status expected %0d got %0d",
					want.status, got.status));
			end
		endfunction

		function int due_count();
			return results_due.size();
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    token_valid;
	logic    token_stall;
	token_t  token;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	expr_checker book;
	int tokens_sent;
	int tx_burst;
	int rx_burst;

	rpn_stack_evaluator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.token_valid  (token_valid),
		.token_stall  (token_stall),
		.token        (token),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw a random wait, with occasional runs of back-to-back requests
	function int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(10, 40);
		end
		return $urandom_range(0, 17);
	endfunction

	function logic signed [DATA_W-1:0] rand_q();
		int s;
		case ($urandom_range(0, 11))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return -32'sd65536;
			4, 5, 6: begin
				s = $urandom_range(0, 4194303);
				return s - 2097152;
			end
			7, 8: begin
				s = $urandom_range(0, 64);
				return (s - 32) <<< FRACTION_BITS;
			end
			default: return $urandom;
		endcase
	endfunction

	function token_t rand_any();
		token_t t;
		t.kind = 1'($urandom_range(0, 1));
		t.operand_value = rand_q();
		t.operator_code = 2'($urandom_range(0, 3));
		t.last_token = 1'b0;
		return t;
	endfunction

	function token_t rand_operand();
		token_t t;
		t = rand_any();
		t.kind = KIND_OPERAND;
		return t;
	endfunction

	function token_t rand_op();
		token_t t;
		t = rand_any();
		t.kind = KIND_OPERATOR;
		t.operand_value = $urandom;
		return t;
	endfunction

	// Present one request after a random gap and hold it until accepted
	task send_token(token_t t);
		int gap;
		gap = draw_wait(tx_burst);
		if (gap > 0) begin
			token_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		token <= t;
		token_valid <= 1'b1;
		do @(posedge clk); while (!(token_valid && !token_stall));
		book.take_token(t);
		tokens_sent++;
	endtask

	task send_num(logic signed [DATA_W-1:0] v, bit last);
		token_t t;
		t = rand_operand();
		t.operand_value = v;
		t.last_token = last;
		send_token(t);
	endtask

	task send_op(op_t op, bit last);
		token_t t;
		t = rand_op();
		t.operator_code = op;
		t.last_token = last;
		send_token(t);
	endtask

	// Build one expression: mostly well formed, some overfull, underflowing or noise
	task run_expression();
		token_t q [$];
		token_t t;
		int shape, depth, operands_left, n;
		shape = $urandom_range(0, 19);
		depth = 0;
		if (shape < 14) begin
			operands_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 10 : 4);
			while (operands_left > 0 || depth > 1) begin
				if (depth >= 2 && (operands_left == 0 || $urandom_range(0, 1) == 1)) begin
					q.push_back(rand_op());
					depth--;
				end else begin
					q.push_back(rand_operand());
					depth++;
					operands_left--;
				end
			end
		end else if (shape < 16) begin
			repeat ($urandom_range(15, 19)) q.push_back(rand_operand());
			repeat ($urandom_range(0, 3)) q.push_back(rand_op());
		end else if (shape < 18) begin
			n = $urandom_range(0, 2);
			repeat (n) q.push_back(rand_operand());
			repeat ((n > 0) ? n : 1) q.push_back(rand_op());
			repeat ($urandom_range(0, 3)) q.push_back(rand_any());
		end else begin
			repeat ($urandom_range(1, 6)) q.push_back(rand_any());
		end
		t = q.pop_back();
		t.last_token = 1'b1;
		q.push_back(t);
		foreach (q[i]) send_token(q[i]);
	endtask

	// Accept results after a random stall and check each one
	task take_results();
		int n;
		forever begin
			n = draw_wait(rx_burst);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
			book.check_result(result);
		end
	endtask

	// End the run when no request moves on either channel for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((token_valid && !token_stall) || (result_valid && !result_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		book = new();
		tokens_sent = 0;
		tx_burst = 0;
		rx_burst = 0;
		arst_n = 1'b0;
		token_valid = 1'b0;
		token = '0;
		result_stall = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			take_results();
		join_none

		// saturating add and subtract
		send_num(Q_MAX, 1'b0);
		send_num(Q_MAX, 1'b0);
		send_op(OP_ADD, 1'b1);
		send_num(Q_MIN, 1'b0);
		send_num(32'sd1, 1'b0);
		send_op(OP_SUB, 1'b1);
		// multiply rounding toward minus infinity, then saturation
		send_num(-32'sd1, 1'b0);
		send_num(32'sh0000_8000, 1'b0);
		send_op(OP_MUL, 1'b1);
		send_num(Q_MAX, 1'b0);
		send_num(Q_MAX, 1'b0);
		send_op(OP_MUL, 1'b1);
		// divide truncation toward zero
		send_num(32'sh0007_0000, 1'b0);
		send_num(-32'sh0003_0000, 1'b0);
		send_op(OP_DIV, 1'b1);
		// divide by zero with positive and zero dividends
		send_num(32'sh0005_0000, 1'b0);
		send_num('0, 1'b0);
		send_op(OP_DIV, 1'b1);
		send_num('0, 1'b0);
		send_num('0, 1'b0);
		send_op(OP_DIV, 1'b1);
		// underflow: later tokens ignored
		send_num(32'sh0001_0000, 1'b0);
		send_op(OP_ADD, 1'b0);
		send_num(32'sh0002_0000, 1'b1);
		send_op(OP_SUB, 1'b1);

		while (tokens_sent < TOKEN_TARGET) begin
			run_expression();
		end
		token_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (book.due_count() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (book.fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: rpn_stack_evaluator.f
design/rpn_pkg.sv
design/rpn_ram.sv
design/rpn_div.sv
design/rpn_dp.sv
design/rpn_ctrl.sv
design/rpn_stack_evaluator.sv
verif/rpn_stack_evaluator_test.sv
